@@ rtl/kti_pkg.sv @@
package kti_pkg;

	localparam int MAX_POINTS = 16;
	localparam int AW         = $clog2(MAX_POINTS);
	localparam int NW         = $clog2(MAX_POINTS + 2);
	localparam int POS_W      = 17;
	localparam int FRAME_W    = 32;
	localparam int PERM_W     = 10;
	localparam int CFG_DW     = 17;
	localparam int CFG_IW     = 3;
	localparam int DIV_STEPS  = 17;
	localparam int DCW        = $clog2(DIV_STEPS);

	localparam logic [17:0] SMOOTH_C    = 18'd196608;
	localparam logic [9:0]  PERM_FULL   = 10'd1000;
	localparam logic [19:0] SPEED_SCALE = 20'd1000000;
	localparam logic [26:0] RECIP_1000  = 27'd68719477;
	localparam int          RECIP_SH    = 36;

	typedef enum logic [CFG_IW-1:0] {
		CFG_ENABLE = 3'd0,
		CFG_DEF_X  = 3'd1,
		CFG_DEF_Y  = 3'd2,
		CFG_SPEED  = 3'd3,
		CFG_SMOOTH = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef struct packed {
		op_t                operation;
		logic [FRAME_W-1:0] frame;
		logic [POS_W-1:0]   point_x;
		logic [POS_W-1:0]   point_y;
	} in_item_t;

	typedef struct packed {
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic             located;
		logic             overflow;
	} out_item_t;

	typedef enum logic [2:0] {
		TB_NONE,
		TB_CLEAR,
		TB_FIRST,
		TB_PEND,
		TB_PUSH
	} tb_op_t;

	typedef enum logic [2:0] {
		RES_ZERO,
		RES_DEF,
		RES_PT,
		RES_LERP,
		RES_OVF
	} res_sel_t;

	typedef struct packed {
		logic          load;
		tb_op_t        tb_op;
		logic          rd_en;
		logic [NW-1:0] rd_idx;
		logic          sp1;
		logic          sp2;
		logic          sp3;
		logic          prv_ld;
		logic          seg_ld;
		logic          div_step;
		logic          i1;
		logic          i2;
		logic          i3;
		logic          i4;
		logic          res_ld;
		res_sel_t      res_sel;
		logic          out_ld;
	} cmd_t;

	typedef struct packed {
		op_t           op;
		logic          en;
		logic [NW-1:0] cnt;
		logic          pv;
		logic [NW-1:0] n;
		logic          fq_le_pt;
		logic          fq_ge_pt;
		logic          keep;
		logic          full;
		logic          out_free;
	} sts_t;

endpackage

@@ rtl/kti_ctrl.sv @@
module kti_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  kti_pkg::sts_t sts,
	output kti_pkg::cmd_t cmd
);
	import kti_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DISP, ST_A_RD, ST_A_S2, ST_A_S3, ST_A_S4,
		ST_Q_P0, ST_Q_PL, ST_Q_SC, ST_DIV,
		ST_I1, ST_I2, ST_I3, ST_I4, ST_I5, ST_FIN
	} state_t;

	state_t         state_q, nxt;
	logic [NW-1:0]  idx_q, idx_n, idx_inc;
	logic [DCW-1:0] cnt_q, cnt_n;

	assign in_stall = (state_q != ST_IDLE);
	assign idx_inc  = idx_q + NW'(1);

	always_comb begin
		cmd   = '0;
		nxt   = state_q;
		idx_n = idx_q;
		cnt_n = cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					nxt      = ST_DISP;
				end
			end
			ST_DISP: begin
				case (sts.op)
					OP_CLEAR: begin
						cmd.tb_op  = TB_CLEAR;
						cmd.res_ld = 1'b1;
						nxt        = ST_FIN;
					end
					OP_APPEND: begin
						if (sts.cnt == '0 && !sts.pv) begin
							cmd.tb_op  = TB_FIRST;
							cmd.res_ld = 1'b1;
							nxt        = ST_FIN;
						end else if (sts.pv && sts.cnt != '0) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_idx = sts.cnt - NW'(1);
							nxt        = ST_A_RD;
						end else begin
							cmd.tb_op  = TB_PEND;
							cmd.res_ld = 1'b1;
							nxt        = ST_FIN;
						end
					end
					OP_QUERY: begin
						if (!sts.en) begin
							cmd.res_ld = 1'b1;
							nxt        = ST_FIN;
						end else if (sts.n == '0) begin
							cmd.res_ld  = 1'b1;
							cmd.res_sel = RES_DEF;
							nxt         = ST_FIN;
						end else begin
							cmd.rd_en = 1'b1;
							nxt       = ST_Q_P0;
						end
					end
					default: begin
						cmd.res_ld = 1'b1;
						nxt        = ST_FIN;
					end
				endcase
			end
			ST_A_RD: begin
				cmd.sp1 = 1'b1;
				nxt     = ST_A_S2;
			end
			ST_A_S2: begin
				cmd.sp2 = 1'b1;
				nxt     = ST_A_S3;
			end
			ST_A_S3: begin
				cmd.sp3 = 1'b1;
				nxt     = ST_A_S4;
			end
			ST_A_S4: begin
				cmd.res_ld = 1'b1;
				nxt        = ST_FIN;
				if (sts.keep) begin
					if (sts.full)
						cmd.res_sel = RES_OVF;
					else
						cmd.tb_op = TB_PUSH;
				end else begin
					cmd.tb_op = TB_PEND;
				end
			end
			ST_Q_P0: begin
				if (sts.n == NW'(1) || sts.fq_le_pt) begin
					cmd.res_ld  = 1'b1;
					cmd.res_sel = RES_PT;
					nxt         = ST_FIN;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_idx = sts.n - NW'(1);
					nxt        = ST_Q_PL;
				end
			end
			ST_Q_PL: begin
				if (sts.fq_ge_pt) begin
					cmd.res_ld  = 1'b1;
					cmd.res_sel = RES_PT;
					nxt         = ST_FIN;
				end else begin
					cmd.rd_en = 1'b1;
					idx_n     = '0;
					nxt       = ST_Q_SC;
				end
			end
			ST_Q_SC: begin
				if (idx_q == '0) begin
					cmd.prv_ld = 1'b1;
					cmd.rd_en  = 1'b1;
					cmd.rd_idx = idx_inc;
					idx_n      = idx_inc;
				end else if (sts.fq_le_pt) begin
					cmd.seg_ld = 1'b1;
					cnt_n      = '0;
					nxt        = ST_DIV;
				end else begin
					cmd.prv_ld = 1'b1;
					if (idx_inc < sts.n) begin
						cmd.rd_en  = 1'b1;
						cmd.rd_idx = idx_inc;
						idx_n      = idx_inc;
					end else begin
						cmd.res_ld  = 1'b1;
						cmd.res_sel = RES_DEF;
						nxt         = ST_FIN;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_n        = cnt_q + DCW'(1);
				if (cnt_q == DCW'(DIV_STEPS - 1))
					nxt = ST_I1;
			end
			ST_I1: begin
				cmd.i1 = 1'b1;
				nxt    = ST_I2;
			end
			ST_I2: begin
				cmd.i2 = 1'b1;
				nxt    = ST_I3;
			end
			ST_I3: begin
				cmd.i3 = 1'b1;
				nxt    = ST_I4;
			end
			ST_I4: begin
				cmd.i4 = 1'b1;
				nxt    = ST_I5;
			end
			ST_I5: begin
				cmd.res_ld  = 1'b1;
				cmd.res_sel = RES_LERP;
				nxt         = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					nxt        = ST_IDLE;
				end
			end
			default: nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= nxt;
			idx_q   <= idx_n;
			cnt_q   <= cnt_n;
		end
	end

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tb_op == TB_PUSH |-> !sts.full) else $error("push into full table");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> sts.out_free) else $error("result overwritten");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.seg_ld |=> cmd.div_step) else $error("divider not started");
endmodule

@@ rtl/kti_dp.sv @@
module kti_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  kti_pkg::in_item_t                in_data,
	input  logic                             cfg_we,
	input  logic [kti_pkg::CFG_IW-1:0]       cfg_index,
	input  logic [kti_pkg::CFG_DW-1:0]       cfg_data,
	input  logic                             out_stall,
	output logic                             out_valid,
	output kti_pkg::out_item_t               out_data,
	input  kti_pkg::cmd_t                    cmd,
	output kti_pkg::sts_t                    sts
);
	import kti_pkg::*;

	function automatic logic [POS_W-1:0] lerp_q16(input logic [POS_W-1:0] p,
		input logic [POS_W-1:0] n, input logic [POS_W-1:0] b);
		logic [POS_W-1:0]     d;
		logic [2*POS_W-1:0]   pr;
		logic [POS_W:0]       r;
		d  = (n >= p) ? n - p : p - n;
		pr = d * b;
		if (n >= p)
			r = {1'b0, p} + pr[2*POS_W-1:16];
		else
			r = {1'b0, p} - pr[2*POS_W-1:16];
		return r[POS_W-1:0];
	endfunction

	logic               en_q;
	logic [POS_W-1:0]   defx_q, defy_q;
	logic [PERM_W-1:0]  mspd_q, smth_q;

	op_t                op_q;
	logic [FRAME_W-1:0] fq_q;
	logic [POS_W-1:0]   nx_q, ny_q;

	logic [FRAME_W-1:0] mem_f [MAX_POINTS];
	logic [POS_W-1:0]   mem_x [MAX_POINTS];
	logic [POS_W-1:0]   mem_y [MAX_POINTS];
	logic [FRAME_W-1:0] rd_f_q;
	logic [POS_W-1:0]   rd_x_q, rd_y_q;
	logic               sel_pend_q;

	logic [NW-1:0]      count_q;
	logic               pv_q;
	logic [FRAME_W-1:0] pf_q;
	logic [POS_W-1:0]   px_q, py_q;

	logic [FRAME_W-1:0] pt_f;
	logic [POS_W-1:0]   pt_x, pt_y;

	logic [FRAME_W-1:0] dt_w;
	logic [PERM_W-1:0]  m_w;
	logic [41:0]        md_w;
	logic [41:0]        md_s1;
	logic [POS_W-1:0]   dx_s1, dy_s1;
	logic               big_s2, big_s3;
	logic [31:0]        md2_s2, md2_s3;
	logic [33:0]        dx2_s2, dy2_s2;
	logic [34:0]        ssq_w;
	logic [54:0]        lhs_w, lhs_s3;

	logic [FRAME_W-1:0] prv_f_q;
	logic [POS_W-1:0]   prv_x_q, prv_y_q, nxt_x_q, nxt_y_q;
	logic [FRAME_W-1:0] span_w, a_w, a_lim;
	logic [FRAME_W:0]   rem_q, rem_diff;
	logic [FRAME_W-1:0] dvs_q;
	logic [POS_W-1:0]   quo_q;
	logic               ge_w;

	logic [33:0]        tt_s1;
	logic [17:0]        c_s1;
	logic [50:0]        smp_w;
	logic [POS_W-1:0]   sm_s2;
	logic [PERM_W-1:0]  s_w, ns_w;
	logic [26:0]        lin_w, smt_w;
	logic [27:0]        num_s3;
	logic [54:0]        bp_w;
	logic [POS_W-1:0]   b_s4;

	logic [POS_W-1:0]   res_x_q, res_y_q;
	logic               res_loc_q, res_ovf_q;
	logic               out_valid_q;
	out_item_t          out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q   <= 1'b0;
			defx_q <= 17'd32768;
			defy_q <= 17'd55706;
			mspd_q <= 10'd40;
			smth_q <= 10'd800;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ENABLE: en_q   <= cfg_data[0];
				CFG_DEF_X:  defx_q <= cfg_data[POS_W-1:0];
				CFG_DEF_Y:  defy_q <= cfg_data[POS_W-1:0];
				CFG_SPEED:  mspd_q <= cfg_data[PERM_W-1:0];
				CFG_SMOOTH: smth_q <= cfg_data[PERM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_data.operation;
			fq_q <= in_data.frame;
			nx_q <= in_data.point_x;
			ny_q <= in_data.point_y;
		end
	end

	// table store
	always_ff @(posedge clk) begin
		if (cmd.tb_op == TB_FIRST) begin
			mem_f[0] <= fq_q;
			mem_x[0] <= nx_q;
			mem_y[0] <= ny_q;
		end else if (cmd.tb_op == TB_PUSH) begin
			mem_f[count_q[AW-1:0]] <= pf_q;
			mem_x[count_q[AW-1:0]] <= px_q;
			mem_y[count_q[AW-1:0]] <= py_q;
		end
		if (cmd.rd_en) begin
			rd_f_q     <= mem_f[cmd.rd_idx[AW-1:0]];
			rd_x_q     <= mem_x[cmd.rd_idx[AW-1:0]];
			rd_y_q     <= mem_y[cmd.rd_idx[AW-1:0]];
			sel_pend_q <= (cmd.rd_idx >= count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pv_q    <= 1'b0;
		end else begin
			case (cmd.tb_op)
				TB_CLEAR: begin
					count_q <= '0;
					pv_q    <= 1'b0;
				end
				TB_FIRST: count_q <= NW'(1);
				TB_PEND:  pv_q    <= 1'b1;
				TB_PUSH: begin
					count_q <= count_q + NW'(1);
					pv_q    <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tb_op == TB_PEND || cmd.tb_op == TB_PUSH) begin
			pf_q <= fq_q;
			px_q <= nx_q;
			py_q <= ny_q;
		end
	end

	assign pt_f = sel_pend_q ? pf_q : rd_f_q;
	assign pt_x = sel_pend_q ? px_q : rd_x_q;
	assign pt_y = sel_pend_q ? py_q : rd_y_q;

	// speed test, pending point against last kept point
	assign dt_w  = (pf_q > pt_f) ? pf_q - pt_f : FRAME_W'(1);
	assign m_w   = (mspd_q == '0) ? PERM_W'(1) : mspd_q;
	assign md_w  = m_w * dt_w;
	assign ssq_w = {1'b0, dx2_s2} + {1'b0, dy2_s2};
	assign lhs_w = ssq_w * SPEED_SCALE;

	always_ff @(posedge clk) begin
		if (cmd.sp1) begin
			md_s1 <= md_w;
			dx_s1 <= (px_q > pt_x) ? px_q - pt_x : pt_x - px_q;
			dy_s1 <= (py_q > pt_y) ? py_q - pt_y : pt_y - py_q;
		end
		if (cmd.sp2) begin
			big_s2 <= (md_s1[41:16] != '0);
			md2_s2 <= md_s1[15:0] * md_s1[15:0];
			dx2_s2 <= dx_s1 * dx_s1;
			dy2_s2 <= dy_s1 * dy_s1;
		end
		if (cmd.sp3) begin
			big_s3 <= big_s2;
			md2_s3 <= md2_s2;
			lhs_s3 <= lhs_w;
		end
	end

	// segment fraction: serial restoring divide, one quotient bit a cycle
	assign span_w   = (pt_f > prv_f_q) ? pt_f - prv_f_q : FRAME_W'(1);
	assign a_w      = (fq_q > prv_f_q) ? fq_q - prv_f_q : '0;
	assign a_lim    = (a_w > span_w) ? span_w : a_w;
	assign ge_w     = (rem_q >= {1'b0, dvs_q});
	assign rem_diff = rem_q - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.prv_ld) begin
			prv_f_q <= pt_f;
			prv_x_q <= pt_x;
			prv_y_q <= pt_y;
		end
		if (cmd.seg_ld) begin
			nxt_x_q <= pt_x;
			nxt_y_q <= pt_y;
			rem_q   <= {1'b0, a_lim};
			dvs_q   <= span_w;
			quo_q   <= '0;
		end else if (cmd.div_step) begin
			rem_q <= {(ge_w ? rem_diff[FRAME_W-1:0] : rem_q[FRAME_W-1:0]), 1'b0};
			quo_q <= {quo_q[POS_W-2:0], ge_w};
		end
	end

	// smoothstep blend
	assign smp_w = tt_s1[32:0] * c_s1;
	assign s_w   = (smth_q > PERM_FULL) ? PERM_FULL : smth_q;
	assign ns_w  = PERM_FULL - s_w;
	assign lin_w = quo_q * ns_w;
	assign smt_w = sm_s2 * s_w;
	assign bp_w  = num_s3 * RECIP_1000;

	always_ff @(posedge clk) begin
		if (cmd.i1) begin
			tt_s1 <= quo_q * quo_q;
			c_s1  <= SMOOTH_C - {quo_q, 1'b0};
		end
		if (cmd.i2)
			sm_s2 <= smp_w[48:32];
		if (cmd.i3)
			num_s3 <= {1'b0, lin_w} + {1'b0, smt_w};
		if (cmd.i4)
			b_s4 <= bp_w[RECIP_SH+POS_W-1:RECIP_SH];
	end

	always_ff @(posedge clk) begin
		if (cmd.res_ld) begin
			case (cmd.res_sel)
				RES_DEF: begin
					res_x_q   <= defx_q;
					res_y_q   <= defy_q;
					res_loc_q <= 1'b1;
					res_ovf_q <= 1'b0;
				end
				RES_PT: begin
					res_x_q   <= pt_x;
					res_y_q   <= pt_y;
					res_loc_q <= 1'b1;
					res_ovf_q <= 1'b0;
				end
				RES_LERP: begin
					res_x_q   <= lerp_q16(prv_x_q, nxt_x_q, b_s4);
					res_y_q   <= lerp_q16(prv_y_q, nxt_y_q, b_s4);
					res_loc_q <= 1'b1;
					res_ovf_q <= 1'b0;
				end
				RES_OVF: begin
					res_x_q   <= '0;
					res_y_q   <= '0;
					res_loc_q <= 1'b0;
					res_ovf_q <= 1'b1;
				end
				default: begin
					res_x_q   <= '0;
					res_y_q   <= '0;
					res_loc_q <= 1'b0;
					res_ovf_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_ld)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_q.pos_x    <= res_x_q;
			out_q.pos_y    <= res_y_q;
			out_q.located  <= res_loc_q;
			out_q.overflow <= res_ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign sts.op       = op_q;
	assign sts.en       = en_q;
	assign sts.cnt      = count_q;
	assign sts.pv       = pv_q;
	assign sts.n        = count_q + NW'(pv_q);
	assign sts.fq_le_pt = (fq_q <= pt_f);
	assign sts.fq_ge_pt = (fq_q >= pt_f);
	assign sts.keep     = big_s3 || ({9'b0, lhs_s3} <= {md2_s3, 32'b0});
	assign sts.full     = (count_q >= NW'(MAX_POINTS));
	assign sts.out_free = !out_valid_q || !out_stall;

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(MAX_POINTS)) else $error("table count past depth");
	a_pend_has_first: assert property (@(posedge clk) disable iff (!arst_n)
		pv_q |-> count_q != '0) else $error("pending point without first point");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !cmd.out_ld) else $error("held item overwritten");
endmodule

@@ rtl/keyframe_track_interpolator_core.sv @@
// Keyframe track interpolator, one tracked position.
// Input channel (in_valid/in_stall/in_data) takes clear, append and query
// items; the output channel (out_valid/out_stall/out_data) returns exactly
// one item for each, in order. An item is taken when valid is high and
// stall is low. Configuration is a plain write port (cfg_we, cfg_index,
// cfg_data), to be written by the user only while idle; the block does not check.
// One item is worked on at a time; in_stall is high until its result is
// loaded into the output register, so the next item may enter while that
// result still waits on out_stall.
// Clear and unused codes go straight to the result; an append with a pending
// point held runs the speed test (a table read and three multiply steps), and
// a query may run the segment search, which reads one table entry per cycle,
// then a serial restoring divide and the blend arithmetic. The next item is
// taken in the cycle after the result is loaded.
// Reset clears the table, the pending point and the output valid, and
// loads the register defaults. A stalled result holds until taken; while
// it is held a finished item waits in the controller.
module keyframe_track_interpolator_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  kti_pkg::in_item_t           in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output kti_pkg::out_item_t          out_data,
	input  logic                        cfg_we,
	input  logic [kti_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [kti_pkg::CFG_DW-1:0]  cfg_data
);
	import kti_pkg::*;

	cmd_t cmd;
	sts_t sts;

	kti_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	kti_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);
endmodule
